// ===== src/nrmc_pkg.sv =====
package nrmc_pkg;

	// ascii codes
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [3:0] NIB_MASK  = 4'h0F;

	localparam int unsigned HDR_LEN = 5;

	// result kinds
	localparam logic [1:0] KIND_SUM = 2'd0;
	localparam logic [1:0] KIND_LAT = 2'd1;
	localparam logic [1:0] KIND_LON = 2'd2;
	localparam logic [1:0] KIND_SPD = 2'd3;

	// summary status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_HDR  = 2'd1;
	localparam logic [1:0] ST_CSUM = 2'd2;

	// field numbers within the sentence, field 0 is the header
	localparam logic [3:0] FLD_STATUS = 4'd2;
	localparam logic [3:0] FLD_LAT    = 4'd3;
	localparam logic [3:0] FLD_NS     = 4'd4;
	localparam logic [3:0] FLD_LON    = 4'd5;
	localparam logic [3:0] FLD_WE     = 4'd6;
	localparam logic [3:0] FLD_SPD    = 4'd7;
	localparam logic [3:0] FLD_MAX    = 4'd15;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_BODY,
		PH_HEXH,
		PH_HEXL,
		PH_HEXBAD,
		PH_EMIT
	} phase_t;

	// controller to datapath
	typedef struct packed {
		logic restart;
		logic body;
		logic star;
		logic hexh;
		logic finish;
		logic finish_hexl;
		logic advance;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_dollar;
		logic is_star;
		logic hex_ok;
		logic out_last;
	} dp_stat_t;

	// expected header text
	function automatic logic [7:0] hdr_char(input logic [2:0] pos);
		logic [7:0] c;
		begin
			unique case (pos)
				3'd0: c = 8'h47;
				3'd1: c = 8'h50;
				3'd2: c = 8'h52;
				3'd3: c = 8'h4D;
				3'd4: c = 8'h43;
				default: c = 8'h00;
			endcase
			return c;
		end
	endfunction

	// 0..15 for a hex digit, 16 otherwise
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'h00;
			if (c >= 8'h30 && c <= 8'h39) begin
				d = c - 8'h30;
				return {1'b0, d[3:0]};
			end
			if (c >= 8'h41 && c <= 8'h46) begin
				d = c - 8'h41 + 8'd10;
				return {1'b0, d[3:0]};
			end
			if (c >= 8'h61 && c <= 8'h66) begin
				d = c - 8'h61 + 8'd10;
				return {1'b0, d[3:0]};
			end
			return 5'd16;
		end
	endfunction

endpackage

// ===== src/nrmc_rx_if.sv =====
interface nrmc_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

// ===== src/nrmc_res_if.sv =====
interface nrmc_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_value;
	logic [1:0] status;
	logic       fix_valid;
	logic [7:0] ns_char;
	logic [7:0] we_char;
	logic       last;

	modport source(output valid, output kind, output char_value, output status,
		output fix_valid, output ns_char, output we_char, output last, input ready);
	modport sink(input valid, input kind, input char_value, input status,
		input fix_valid, input ns_char, input we_char, input last, output ready);
endinterface

// ===== src/nrmc_ctrl.sv =====
module nrmc_ctrl
	import nrmc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	phase_t phase_q;
	phase_t phase_d;
	logic   in_fire;
	logic   out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		if (phase_q == PH_EMIT) begin
			if (out_fire && stat.out_last) begin
				phase_d = PH_IDLE;
			end
		end else if (in_fire) begin
			if (stat.is_dollar) begin
				phase_d = PH_BODY;
			end else begin
				unique case (phase_q)
					PH_IDLE:   phase_d = PH_IDLE;
					PH_BODY:   phase_d = stat.is_star ? PH_HEXH : PH_BODY;
					PH_HEXH:   phase_d = stat.hex_ok ? PH_HEXL : PH_HEXBAD;
					PH_HEXL:   phase_d = PH_EMIT;
					PH_HEXBAD: phase_d = PH_EMIT;
					default:   phase_d = PH_IDLE;
				endcase
			end
		end
	end

	always_comb begin
		in_ready        = (phase_q != PH_EMIT);
		out_valid       = (phase_q == PH_EMIT);
		cmd.restart     = in_fire && stat.is_dollar;
		cmd.body        = in_fire && !stat.is_dollar && !stat.is_star && phase_q == PH_BODY;
		cmd.star        = in_fire && !stat.is_dollar && stat.is_star && phase_q == PH_BODY;
		cmd.hexh        = in_fire && !stat.is_dollar && phase_q == PH_HEXH;
		cmd.finish      = in_fire && !stat.is_dollar
			&& (phase_q == PH_HEXL || phase_q == PH_HEXBAD);
		cmd.finish_hexl = (phase_q == PH_HEXL);
		cmd.advance     = out_fire && !stat.out_last;
	end

endmodule

// ===== src/nrmc_dp.sv =====
module nrmc_dp
	import nrmc_pkg::*;
#(
	parameter int unsigned FIELD_CHARS = 16
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  ctrl_cmd_t  cmd,
	output dp_stat_t   stat,
	output logic [1:0] kind,
	output logic [7:0] char_value,
	output logic [1:0] status,
	output logic       fix_valid,
	output logic [7:0] ns_char,
	output logic [7:0] we_char,
	output logic       last
);

	localparam int unsigned LEN_W = $clog2(FIELD_CHARS + 1);
	localparam int unsigned IDX_W = (FIELD_CHARS > 1) ? $clog2(FIELD_CHARS) : 1;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(FIELD_CHARS);

	typedef struct packed {
		logic             found;
		logic [1:0]       k;
		logic [IDX_W-1:0] i;
	} pos_t;

	// sentence parse state
	logic [2:0]       hdr_pos_q;
	logic             hdr_match_q;
	logic [3:0]       fld_idx_q;
	logic             fld_started_q;
	logic [7:0]       xor_q;
	logic [3:0]       hi_nib_q;
	logic             fix_q;
	logic [7:0]       ns_q;
	logic [7:0]       we_q;
	logic [LEN_W-1:0] lat_len_q;
	logic [LEN_W-1:0] lon_len_q;
	logic [LEN_W-1:0] spd_len_q;

	logic [7:0] lat_mem [FIELD_CHARS];
	logic [7:0] lon_mem [FIELD_CHARS];
	logic [7:0] spd_mem [FIELD_CHARS];

	// result register and read pointer
	logic [1:0]       kind_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       char_q;
	logic [1:0]       status_q;
	logic             fix_out_q;
	logic [7:0]       ns_out_q;
	logic [7:0]       we_out_q;
	logic             last_q;

	logic [4:0] hv;
	logic [1:0] st;
	pos_t       p0;
	pos_t       p1;
	pos_t       p2;

	function automatic pos_t next_pos(input logic [1:0] k, input logic [IDX_W-1:0] i,
		input logic [LEN_W-1:0] la, input logic [LEN_W-1:0] lo, input logic [LEN_W-1:0] sp);
		pos_t             r;
		logic [LEN_W-1:0] cur_len;
		logic [LEN_W-1:0] nxt_i;
		begin
			case (k)
				KIND_LAT: cur_len = la;
				KIND_LON: cur_len = lo;
				KIND_SPD: cur_len = sp;
				default:  cur_len = '0;
			endcase
			nxt_i   = LEN_W'(i) + LEN_W'(1);
			r.found = 1'b0;
			r.k     = k;
			r.i     = i;
			if (k != KIND_SUM && nxt_i < cur_len) begin
				r.found = 1'b1;
				r.i     = nxt_i[IDX_W-1:0];
			end else if (k == KIND_SUM && la != '0) begin
				r = '{found: 1'b1, k: KIND_LAT, i: '0};
			end else if ((k == KIND_SUM || k == KIND_LAT) && lo != '0) begin
				r = '{found: 1'b1, k: KIND_LON, i: '0};
			end else if (k != KIND_SPD && sp != '0) begin
				r = '{found: 1'b1, k: KIND_SPD, i: '0};
			end
			return r;
		end
	endfunction

	assign hv = hex_value(rx_byte);

	assign stat.is_dollar = (rx_byte == CH_DOLLAR);
	assign stat.is_star   = (rx_byte == CH_STAR);
	assign stat.hex_ok    = !hv[4];
	assign stat.out_last  = last_q;

	always_comb begin
		if (!hdr_match_q) begin
			st = ST_HDR;
		end else if (cmd.finish_hexl && !hv[4] && hi_nib_q == xor_q[7:4]
			&& hv[3:0] == (xor_q[3:0] & NIB_MASK)) begin
			st = ST_OK;
		end else begin
			st = ST_CSUM;
		end
	end

	always_comb begin
		p0 = next_pos(KIND_SUM, '0, lat_len_q, lon_len_q, spd_len_q);
		p1 = next_pos(kind_q, idx_q, lat_len_q, lon_len_q, spd_len_q);
		p2 = next_pos(p1.k, p1.i, lat_len_q, lon_len_q, spd_len_q);
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q     <= '0;
			hdr_match_q   <= 1'b1;
			fld_idx_q     <= '0;
			fld_started_q <= 1'b0;
			xor_q         <= '0;
			hi_nib_q      <= '0;
			fix_q         <= 1'b0;
			ns_q          <= '0;
			we_q          <= '0;
			lat_len_q     <= '0;
			lon_len_q     <= '0;
			spd_len_q     <= '0;
		end else if (cmd.restart) begin
			hdr_pos_q     <= '0;
			hdr_match_q   <= 1'b1;
			fld_idx_q     <= '0;
			fld_started_q <= 1'b0;
			xor_q         <= '0;
			hi_nib_q      <= '0;
			fix_q         <= 1'b0;
			ns_q          <= '0;
			we_q          <= '0;
			lat_len_q     <= '0;
			lon_len_q     <= '0;
			spd_len_q     <= '0;
		end else if (cmd.star) begin
			if (hdr_pos_q < 3'(HDR_LEN)) begin
				hdr_match_q <= 1'b0;
			end
		end else if (cmd.hexh) begin
			hi_nib_q <= hv[3:0];
		end else if (cmd.body) begin
			xor_q <= xor_q ^ rx_byte;
			if (hdr_pos_q < 3'(HDR_LEN)) begin
				if (rx_byte != hdr_char(hdr_pos_q)) begin
					hdr_match_q <= 1'b0;
				end
				hdr_pos_q <= hdr_pos_q + 3'd1;
			end
			if (rx_byte == CH_COMMA) begin
				if (fld_idx_q < FLD_MAX) begin
					fld_idx_q <= fld_idx_q + 4'd1;
				end
				fld_started_q <= 1'b0;
			end else begin
				fld_started_q <= 1'b1;
				case (fld_idx_q)
					FLD_STATUS: if (!fld_started_q) fix_q <= (rx_byte == CH_A);
					FLD_NS:     if (!fld_started_q) ns_q <= rx_byte;
					FLD_WE:     if (!fld_started_q) we_q <= rx_byte;
					FLD_LAT:    if (lat_len_q < LEN_MAX) lat_len_q <= lat_len_q + LEN_W'(1);
					FLD_LON:    if (lon_len_q < LEN_MAX) lon_len_q <= lon_len_q + LEN_W'(1);
					FLD_SPD:    if (spd_len_q < LEN_MAX) spd_len_q <= spd_len_q + LEN_W'(1);
					default:    ;
				endcase
			end
		end
	end

	// character stores
	always_ff @(posedge clk) begin
		if (cmd.body && rx_byte != CH_COMMA) begin
			case (fld_idx_q)
				FLD_LAT: if (lat_len_q < LEN_MAX) lat_mem[lat_len_q[IDX_W-1:0]] <= rx_byte;
				FLD_LON: if (lon_len_q < LEN_MAX) lon_mem[lon_len_q[IDX_W-1:0]] <= rx_byte;
				FLD_SPD: if (spd_len_q < LEN_MAX) spd_mem[spd_len_q[IDX_W-1:0]] <= rx_byte;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			kind_q <= KIND_SUM;
			idx_q  <= '0;
		end else if (cmd.finish) begin
			kind_q <= KIND_SUM;
			idx_q  <= '0;
			last_q <= (st != ST_OK) || !p0.found;
		end else if (cmd.advance) begin
			kind_q <= p1.k;
			idx_q  <= p1.i;
			last_q <= !p2.found;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			char_q    <= 8'h00;
			status_q  <= st;
			fix_out_q <= (st == ST_OK) ? fix_q : 1'b0;
			ns_out_q  <= (st == ST_OK) ? ns_q : 8'h00;
			we_out_q  <= (st == ST_OK) ? we_q : 8'h00;
		end else if (cmd.advance) begin
			case (p1.k)
				KIND_LAT: char_q <= lat_mem[p1.i];
				KIND_LON: char_q <= lon_mem[p1.i];
				KIND_SPD: char_q <= spd_mem[p1.i];
				default:  char_q <= 8'h00;
			endcase
			status_q  <= ST_OK;
			fix_out_q <= 1'b0;
			ns_out_q  <= 8'h00;
			we_out_q  <= 8'h00;
		end
	end

	assign kind       = kind_q;
	assign char_value = char_q;
	assign status     = status_q;
	assign fix_valid  = fix_out_q;
	assign ns_char    = ns_out_q;
	assign we_char    = we_out_q;
	assign last       = last_q;

endmodule

// ===== src/nmea_rmc_sentence_parser_unit.sv =====
// nmea 0183 rmc sentence parser: takes one ascii character per beat on rx and
// checks the "GPRMC" header and the xor checksum given by the two hex digits
// after '*'. a '$' restarts the sentence at any point. the second checksum digit
// produces a summary beat on res (status, fix flag, n/s and e/w characters);
// when the sentence is accepted the latitude, longitude and speed characters
// follow, one per beat, and the final beat carries last. each field keeps at
// most FIELD_CHARS characters. rate: a character is taken every cycle while the
// block is parsing; after the closing checksum digit no character is taken until
// the result run of 1 to 1 + 3 * FIELD_CHARS beats has drained from the output
// register, one beat per cycle while the sink does not stall.
module nmea_rmc_sentence_parser_unit
	import nrmc_pkg::*;
#(
	parameter int unsigned FIELD_CHARS = 16
)
(
	input  logic    clk,
	input  logic    arst_n,
	nrmc_rx_if.sink rx,
	nrmc_res_if.source res
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// phase sequencing and handshakes
	nrmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// header check, checksum, field capture and the result register
	nrmc_dp #(
		.FIELD_CHARS(FIELD_CHARS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx.rx_byte),
		.cmd       (cmd),
		.stat      (stat),
		.kind      (res.kind),
		.char_value(res.char_value),
		.status    (res.status),
		.fix_valid (res.fix_valid),
		.ns_char   (res.ns_char),
		.we_char   (res.we_char),
		.last      (res.last)
	);

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	import nrmc_pkg::*;

	localparam int unsigned FIELD_CHARS  = 16;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 3 * FIELD_CHARS + 8;
	localparam logic [8*HDR_LEN-1:0] RMC_TAG = "GPRMC";

	typedef logic [7:0] byte_q_t [$];

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_value;
		logic [1:0] status;
		logic       fix_valid;
		logic [7:0] ns_char;
		logic [7:0] we_char;
		logic       last;
	} rmc_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	nrmc_rx_if  rx();
	nrmc_res_if res();

	nmea_rmc_sentence_parser_unit #(.FIELD_CHARS(FIELD_CHARS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.res    (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sentence tracker state, mirrors what the parser should hold
	phase_t     trk_phase;
	logic [2:0] trk_hdr_pos;
	logic       trk_hdr_ok;
	logic [3:0] trk_field;
	logic       trk_field_open;
	logic [7:0] trk_xor;
	logic [3:0] trk_sum_hi;
	logic       trk_fix;
	logic [7:0] trk_ns;
	logic [7:0] trk_we;
	byte_q_t    trk_lat;
	byte_q_t    trk_lon;
	byte_q_t    trk_spd;

	rmc_beat_t expected_beats [$];

	int unsigned mismatches   = 0;
	int unsigned beats_seen   = 0;
	int unsigned beats_queued = 0;
	int unsigned bytes_sent   = 0;
	int unsigned noise_sent   = 0;
	int unsigned n_accepted   = 0;
	int unsigned n_hdr_reject = 0;
	int unsigned n_sum_reject = 0;
	int unsigned cycle_count  = 0;
	bit          calm         = 1'b0;

	function automatic logic [7:0] tag_char(input int pos);
		return RMC_TAG[8*(HDR_LEN-1-pos) +: 8];
	endfunction

	// bit 4 set when the byte is not a hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= "0" && c <= "9")
			v = 5'(c - "0");
		else if (c >= "A" && c <= "F")
			v = 5'(c - "A" + 10);
		else if (c >= "a" && c <= "f")
			v = 5'(c - "a" + 10);
		return v;
	endfunction

	// letters in either case, picked at random
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10)
			return "0" + n;
		if ($urandom_range(1))
			return 8'("a" + n - 10);
		return 8'("A" + n - 10);
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] c;
		logic [4:0] v;
		c = 8'($urandom_range(255));
		v = hex_nibble(c);
		while (!v[4] || c == CH_DOLLAR) begin
			c = 8'($urandom_range(255));
			v = hex_nibble(c);
		end
		return c;
	endfunction

	function automatic byte_q_t to_bytes(input string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	function automatic rmc_beat_t char_beat(input logic [1:0] kind, input logic [7:0] c);
		rmc_beat_t b;
		b = '0;
		b.kind = kind;
		b.char_value = c;
		return b;
	endfunction

	task automatic clear_sentence();
		trk_hdr_pos = '0;
		trk_hdr_ok = 1'b1;
		trk_field = '0;
		trk_field_open = 1'b0;
		trk_xor = '0;
		trk_sum_hi = '0;
		trk_fix = 1'b0;
		trk_ns = '0;
		trk_we = '0;
		trk_lat.delete();
		trk_lon.delete();
		trk_spd.delete();
	endtask

	// advance the tracker by one accepted byte and queue the beats it causes
	task automatic track_byte(input logic [7:0] c);
		logic [4:0] nib;
		logic [1:0] verdict;
		rmc_beat_t  b;
		rmc_beat_t  run [$];
		if (c == CH_DOLLAR) begin
			clear_sentence();
			trk_phase = PH_BODY;
			return;
		end
		case (trk_phase)
			PH_BODY: begin
				if (c == CH_STAR) begin
					if (trk_hdr_pos < HDR_LEN)
						trk_hdr_ok = 1'b0;
					trk_phase = PH_HEXH;
				end else begin
					trk_xor ^= c;
					if (trk_hdr_pos < HDR_LEN) begin
						if (c != tag_char(trk_hdr_pos))
							trk_hdr_ok = 1'b0;
						trk_hdr_pos++;
					end
					if (c == CH_COMMA) begin
						if (trk_field < FLD_MAX)
							trk_field++;
						trk_field_open = 1'b0;
					end else begin
						case (trk_field)
							FLD_STATUS: if (!trk_field_open) trk_fix = (c == CH_A);
							FLD_LAT: if (trk_lat.size() < FIELD_CHARS) trk_lat.push_back(c);
							FLD_NS: if (!trk_field_open) trk_ns = c;
							FLD_LON: if (trk_lon.size() < FIELD_CHARS) trk_lon.push_back(c);
							FLD_WE: if (!trk_field_open) trk_we = c;
							FLD_SPD: if (trk_spd.size() < FIELD_CHARS) trk_spd.push_back(c);
							default: ;
						endcase
						trk_field_open = 1'b1;
					end
				end
			end
			PH_HEXH: begin
				nib = hex_nibble(c);
				if (nib[4]) begin
					trk_phase = PH_HEXBAD;
				end else begin
					trk_sum_hi = nib[3:0];
					trk_phase = PH_HEXL;
				end
			end
			PH_HEXL, PH_HEXBAD: begin
				nib = hex_nibble(c);
				// a bad header wins over a bad checksum
				if (!trk_hdr_ok)
					verdict = ST_HDR;
				else if (trk_phase == PH_HEXL && !nib[4] && {trk_sum_hi, nib[3:0]} == trk_xor)
					verdict = ST_OK;
				else
					verdict = ST_CSUM;
				trk_phase = PH_IDLE;
				b = '0;
				b.kind = KIND_SUM;
				b.status = verdict;
				if (verdict == ST_OK) begin
					b.fix_valid = trk_fix;
					b.ns_char = trk_ns;
					b.we_char = trk_we;
				end
				run.push_back(b);
				if (verdict == ST_OK) begin
					foreach (trk_lat[i]) run.push_back(char_beat(KIND_LAT, trk_lat[i]));
					foreach (trk_lon[i]) run.push_back(char_beat(KIND_LON, trk_lon[i]));
					foreach (trk_spd[i]) run.push_back(char_beat(KIND_SPD, trk_spd[i]));
					n_accepted++;
				end else if (verdict == ST_HDR) begin
					n_hdr_reject++;
				end else begin
					n_sum_reject++;
				end
				run[run.size()-1].last = 1'b1;
				foreach (run[i]) expected_beats.push_back(run[i]);
				beats_queued += run.size();
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("beat %0d %s got %02h want %02h", beats_seen, name, got,
				want));
	endtask

	task automatic check_beat();
		rmc_beat_t want;
		if (expected_beats.size() == 0) begin
			report_mismatch($sformatf("unexpected beat kind %0d char %02h status %0d",
				res.kind, res.char_value, res.status));
			return;
		end
		want = expected_beats.pop_front();
		beats_seen++;
		cmp_field("kind", 8'(res.kind), 8'(want.kind));
		cmp_field("char_value", res.char_value, want.char_value);
		cmp_field("status", 8'(res.status), 8'(want.status));
		cmp_field("fix_valid", 8'(res.fix_valid), 8'(want.fix_valid));
		cmp_field("ns_char", res.ns_char, want.ns_char);
		cmp_field("we_char", res.we_char, want.we_char);
		cmp_field("last", 8'(res.last), 8'(want.last));
	endtask

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			check_beat();
	end

	// result side back-pressure
	always @(negedge clk)
		res.ready <= calm || ($urandom_range(99) >= 24);

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// one character beat; valid may drop for random gaps before it, except while calm
	task automatic send_byte(input logic [7:0] c);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 24) begin
			rx.valid <= 1'b0;
			@(negedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= c;
		do @(posedge clk); while (!rx.ready);
		track_byte(c);
		bytes_sent++;
	endtask

	task automatic send_noise(input logic [7:0] c);
		send_byte(c);
		noise_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// '$', body, '*', two digits; flip spoils the checksum, bad_digit 1 or 2 puts
	// a non-hex byte in the high or low digit
	task automatic send_sentence(input byte_q_t body, input logic [7:0] flip,
			input int bad_digit);
		logic [7:0] sum;
		logic [7:0] hi;
		logic [7:0] lo;
		sum = flip;
		foreach (body[i]) sum ^= body[i];
		hi = hex_char(sum[7:4]);
		lo = hex_char(sum[3:0]);
		if (bad_digit == 1)
			hi = non_hex_byte();
		else if (bad_digit == 2)
			lo = non_hex_byte();
		send_byte(CH_DOLLAR);
		foreach (body[i]) send_byte(body[i]);
		send_byte(CH_STAR);
		send_byte(hi);
		send_byte(lo);
	endtask

	// sender holds off until every queued beat has come back
	task automatic drain_results();
		@(negedge clk);
		rx.valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] field_byte();
		logic [7:0] c;
		if ($urandom_range(3) != 0)
			return 8'("0" + $urandom_range(9));
		c = 8'($urandom_range(255));
		while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA)
			c = 8'($urandom_range(255));
		return c;
	endfunction

	task automatic add_field(ref byte_q_t body, input int len);
		body.push_back(CH_COMMA);
		repeat (len) body.push_back(field_byte());
	endtask

	task automatic add_flag_field(ref byte_q_t body, input logic [7:0] a, input logic [7:0] b);
		int r;
		r = $urandom_range(99);
		body.push_back(CH_COMMA);
		if (r < 20)
			return;
		if (r < 55)
			body.push_back(a);
		else if (r < 85)
			body.push_back(b);
		else
			body.push_back(field_byte());
		// a second character must not change what was captured
		if ($urandom_range(9) == 0)
			body.push_back(field_byte());
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return 0;
		if (r < 94)
			return $urandom_range(1, 5);
		return $urandom_range(FIELD_CHARS - 1, FIELD_CHARS + 5);
	endfunction

	task automatic test_accepted_sentence();
		send_sentence(to_bytes("GPRMC,1,A,48.1,N,11.2,E,2.4"), 8'h00, 0);
	endtask

	task automatic test_empty_and_missing_fields();
		send_sentence(to_bytes("GPRMC,,,,,,,"), 8'h00, 0);
		send_sentence(to_bytes("GPRMC"), 8'h00, 0);
	endtask

	task automatic test_header_faults();
		// too short, wrong letter, then empty header, each with a wrong checksum too
		send_text("$GPRM*00");
		send_text("$GPRMX*00");
		send_text("$*1Z");
	endtask

	task automatic test_checksum_faults();
		send_sentence(to_bytes("GPRMC"), 8'h01, 0);
		send_sentence(to_bytes("GPRMC"), 8'h00, 1);
		send_sentence(to_bytes("GPRMC"), 8'h00, 2);
	endtask

	task automatic test_restart();
		// mid body, in place of the low digit, in place of the high digit
		send_text("$GPRMC,1");
		send_text("$GPRMC*4");
		send_text("$GPRMC*");
		send_sentence(to_bytes("GPRMC,,A"), 8'h00, 0);
	endtask

	task automatic test_long_fields();
		byte_q_t body;
		body = to_bytes("GPRMC,,");
		add_field(body, FIELD_CHARS + 1);
		send_sentence(body, 8'h00, 0);
	endtask

	// field count saturates, so the character after many commas is never captured
	task automatic test_many_fields();
		byte_q_t body;
		body = to_bytes("GPRMC");
		repeat (19) body.push_back(CH_COMMA);
		body.push_back("9");
		send_sentence(body, 8'h00, 0);
	endtask

	task automatic test_byte_extremes();
		byte_q_t body;
		send_noise(8'h00);
		send_noise(8'hFF);
		body = to_bytes("GPRMC,,,");
		body.push_back(8'h00);
		body.push_back(8'hFF);
		body.push_back(8'h80);
		body.push_back(8'h7F);
		send_sentence(body, 8'h00, 0);
	endtask

	task automatic send_random_sentence();
		byte_q_t body;
		int      mode;
		int      nfields;
		int      cut;
		logic [7:0] flip;
		int      bad_digit;
		if ($urandom_range(99) < 30)
			repeat ($urandom_range(1, 2)) send_noise(non_hex_byte());
		for (int i = 0; i < HDR_LEN; i++)
			body.push_back(tag_char(i));
		mode = $urandom_range(99);
		flip = 8'h00;
		bad_digit = 0;
		if (mode >= 70 && mode < 76)
			body[$urandom_range(HDR_LEN - 1)] = 8'("A" + $urandom_range(25));
		else if (mode >= 76 && mode < 80)
			body = body[0:$urandom_range(HDR_LEN - 2)];
		else if (mode >= 80 && mode < 86)
			flip = 8'($urandom_range(1, 255));
		else if (mode >= 86 && mode < 91)
			bad_digit = $urandom_range(1, 2);
		if (mode < 76 || mode >= 80) begin
			nfields = ($urandom_range(99) < 85) ? 7 : $urandom_range(0, 16);
			for (int f = 1; f <= nfields; f++) begin
				case (f)
					1: add_field(body, $urandom_range(0, 3));
					FLD_STATUS: add_flag_field(body, CH_A, "V");
					FLD_NS: add_flag_field(body, "N", "S");
					FLD_WE: add_flag_field(body, "E", "W");
					FLD_LAT, FLD_LON, FLD_SPD: add_field(body, pick_len());
					default: add_field(body, $urandom_range(0, 3));
				endcase
			end
		end
		// broken start that a fresh '$' throws away
		if (mode >= 91) begin
			cut = $urandom_range(body.size() - 1);
			send_byte(CH_DOLLAR);
			for (int i = 0; i < cut; i++)
				send_byte(body[i]);
			if ($urandom_range(1)) begin
				send_byte(CH_STAR);
				send_byte(hex_char(4'($urandom_range(15))));
			end
		end
		send_sentence(body, flip, bad_digit);
	endtask

	task automatic test_random_traffic();
		int unsigned k;
		k = 0;
		while (bytes_sent < 220 || k < 3) begin
			k++;
			// one long stretch where neither side idles
			calm = (k <= 2);
			if (k == 3 || (!calm && $urandom_range(9) == 0))
				drain_results();
			send_random_sentence();
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		res.ready = 1'b0;
		trk_phase = PH_IDLE;
		clear_sentence();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_accepted_sentence();
		test_empty_and_missing_fields();
		test_header_faults();
		test_checksum_faults();
		test_restart();
		test_long_fields();
		test_many_fields();
		test_byte_extremes();
		test_random_traffic();

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d character beats (%0d ignored before a start) and %0d of %0d result beats",
			bytes_sent, noise_sent, beats_seen, beats_queued);
		$display("sentences: %0d accepted, %0d bad header, %0d bad checksum; %0d mismatches",
			n_accepted, n_hdr_reject, n_sum_reject, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
src/nrmc_pkg.sv
src/nrmc_rx_if.sv
src/nrmc_res_if.sv
src/nrmc_ctrl.sv
src/nrmc_dp.sv
src/nmea_rmc_sentence_parser_unit.sv
tb/sv/testbench.sv
